// File: rtl/core/htwd_pkg.sv
// Shared types and constants of the tree-walk decoder.
package htwd_pkg;

	localparam int NODE_COUNT = 512;
	localparam int IDX_W      = 9;
	localparam int SYM_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 4;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_USER_W = 3;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic             leaf;
		logic             has_left;
		logic [IDX_W-1:0] left;
		logic             has_right;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] symbol;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef enum logic {
		FUNC_NODE = 1'b0,
		FUNC_BYTE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STAT_SYMBOL     = 2'd0,
		STAT_MISSING    = 2'd1,
		STAT_INCOMPLETE = 2'd2
	} status_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		status_t          status;
		logic             msg_end;
	} result_t;

endpackage

// File: rtl/core/huffman_tree_walk_decoder_top.sv
// Top level of the Huffman tree-walk decoder: sequencer around the node memory.
//
// channel  | dir | beat carries
// ---------+-----+---------------------------------------------------------------
// s_axis   | in  | node write (tuser=0) or compressed byte (tuser=1), tlast=final
// m_axis   | out | symbol, status and item-last flag, tlast=message end
// cfg      | in  | root node index, written on cfg_we
//
// A node beat is written to the node memory in the cycle it is accepted.
// A byte beat issues the read of the current node as it is accepted. Each bit then
// passes ST_CUR, which tests the node and reads the chosen child, and ST_CHILD,
// which tests the child and, on a leaf, reads the root; a leaf root needs ST_CUR only.
// A byte goes through accept, bit walk, end check (ST_ENDC) and flush (ST_FLUSH);
// a missing child skips the end check. The dependent node memory read paces the walk.
// Under an error hold a byte is dropped in ST_IDLE; the final one moves to flush.
// Reset clears the walk, error and handshake state; the node memory holds
// garbage until written. A full output register stalls the walk in place.
module huffman_tree_walk_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// node_index[8:0] node_is_leaf[9] node_has_left[10] node_left[19:11]
	// node_has_right[20] node_right[29:21] node_symbol[37:30] data_byte[45:38]
	// valid_bits[49:46], zero fill above
	input  logic [htwd_pkg::IN_DATA_W-1:0]    s_tdata,
	// func[0]
	input  logic                              s_tuser,
	// last_byte
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// symbol[7:0]
	output logic [htwd_pkg::SYM_W-1:0]        m_tdata,
	// status[1:0] last[2]
	output logic [htwd_pkg::OUT_USER_W-1:0]   m_tuser,
	// message_end
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [htwd_pkg::IDX_W-1:0]        cfg_wdata
);

	import htwd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CUR   = 5'b00010,
		ST_CHILD = 5'b00100,
		ST_ENDC  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t             state_q;
	idx_t               root_q;
	idx_t               walk_q;
	logic               error_hold_q;
	logic [BYTE_W-1:0]  sh_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               final_q;

	// Pending result: held back until we know whether it is the item's last.
	logic               pend_valid_q;
	result_t            pend_q;

	logic               out_valid_q;
	result_t            out_q;
	logic               out_last_q;

	// Input beat fields
	idx_t               in_index;
	node_t              in_node;
	logic [BYTE_W-1:0]  in_byte;
	logic [CNT_W-1:0]   in_vbits;
	logic [CNT_W-1:0]   in_nbits;

	// Node memory
	logic               ram_we;
	logic               ram_re;
	idx_t               ram_raddr;
	logic [NODE_W-1:0]  ram_rdata;
	node_t              cur;

	logic               bit_one;
	logic               more;
	logic               closing;
	logic               missing;
	idx_t               child;
	logic               accept;

	logic               gen;
	result_t            gen_res;
	logic               out_free;
	logic               push;
	logic               stall;

	assign in_index         = s_tdata[8:0];
	assign in_node.leaf     = s_tdata[9];
	assign in_node.has_left = s_tdata[10];
	assign in_node.left     = s_tdata[19:11];
	assign in_node.has_right = s_tdata[20];
	assign in_node.right    = s_tdata[29:21];
	assign in_node.symbol   = s_tdata[37:30];
	assign in_byte          = s_tdata[45:38];
	assign in_vbits         = s_tdata[49:46];

	// Final byte uses 1..8 low bits; any other byte uses all eight.
	always_comb begin
		if (!s_tlast) begin
			in_nbits = CNT_W'(BYTE_W);
		end else if (in_vbits == '0) begin
			in_nbits = CNT_W'(1);
		end else if (in_vbits > CNT_W'(BYTE_W)) begin
			in_nbits = CNT_W'(BYTE_W);
		end else begin
			in_nbits = in_vbits;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign ram_we   = accept && (s_tuser == FUNC_NODE);

	assign cur     = node_t'(ram_rdata);
	assign bit_one = sh_q[BYTE_W-1];
	assign more    = (cnt_q > CNT_W'(1));
	assign closing = final_q && (cnt_q == CNT_W'(1));
	assign missing = bit_one ? !cur.has_right : !cur.has_left;
	assign child   = bit_one ? cur.right : cur.left;

	htwd_ram #(
		.WIDTH (NODE_W),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_index),
		.wdata (in_node),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Decide per state what to read and what result to produce.
	logic rd_req;

	always_comb begin
		rd_req    = 1'b0;
		ram_raddr = walk_q;
		gen       = 1'b0;
		gen_res   = '{symbol: '0, status: STAT_SYMBOL, msg_end: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tuser == FUNC_BYTE) begin
					if (error_hold_q) begin
						if (s_tlast) begin
							gen     = 1'b1;
							gen_res = '{symbol: '0, status: STAT_MISSING, msg_end: 1'b1};
						end
					end else begin
						rd_req    = 1'b1;
						ram_raddr = walk_q;
					end
				end
			end
			ST_CUR: begin
				if (cur.leaf) begin
					gen       = 1'b1;
					gen_res   = '{symbol: cur.symbol, status: STAT_SYMBOL, msg_end: closing};
					rd_req    = more;
					ram_raddr = root_q;
				end else if (missing) begin
					gen     = 1'b1;
					gen_res = '{symbol: '0, status: STAT_MISSING, msg_end: final_q};
				end else begin
					rd_req    = 1'b1;
					ram_raddr = child;
				end
			end
			ST_CHILD: begin
				if (cur.leaf) begin
					gen       = 1'b1;
					gen_res   = '{symbol: cur.symbol, status: STAT_SYMBOL, msg_end: closing};
					rd_req    = more;
					ram_raddr = root_q;
				end
			end
			ST_ENDC: begin
				if (final_q && walk_q != root_q) begin
					gen     = 1'b1;
					gen_res = '{symbol: '0, status: STAT_INCOMPLETE, msg_end: 1'b1};
				end
			end
			ST_FLUSH: begin
			end
			default: begin
			end
		endcase
	end

	// A new result or the flush pushes the pending one into the output register.
	assign out_free = !out_valid_q || m_tready;
	assign push     = (gen || state_q == ST_FLUSH) && pend_valid_q;
	assign stall    = push && !out_free;
	assign ram_re   = rd_req && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			root_q       <= '0;
			walk_q       <= '0;
			error_hold_q <= 1'b0;
			cnt_q        <= '0;
			final_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// load or drain the output register
			if (!stall && push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (!stall) begin
				if (gen) begin
					pend_valid_q <= 1'b1;
				end else if (push) begin
					pend_valid_q <= 1'b0;
				end

				unique case (state_q)
					ST_IDLE: begin
						if (accept && s_tuser == FUNC_BYTE) begin
							final_q <= s_tlast;
							if (error_hold_q) begin
								if (s_tlast) begin
									error_hold_q <= 1'b0;
									walk_q       <= root_q;
									state_q      <= ST_FLUSH;
								end
							end else begin
								cnt_q   <= in_nbits;
								state_q <= ST_CUR;
							end
						end
					end
					ST_CUR: begin
						if (cur.leaf) begin
							walk_q  <= root_q;
							cnt_q   <= cnt_q - CNT_W'(1);
							state_q <= more ? ST_CUR : ST_ENDC;
						end else if (missing) begin
							walk_q       <= root_q;
							error_hold_q <= !final_q;
							state_q      <= ST_FLUSH;
						end else begin
							walk_q  <= child;
							state_q <= ST_CHILD;
						end
					end
					ST_CHILD: begin
						if (cur.leaf) begin
							walk_q <= root_q;
						end
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= more ? ST_CUR : ST_ENDC;
					end
					ST_ENDC: begin
						if (gen) begin
							walk_q <= root_q;
						end
						state_q <= ST_FLUSH;
					end
					ST_FLUSH: begin
						state_q <= ST_IDLE;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end

			// the user must make root writes arrive only while idle; the block leaves this unchecked
			if (cfg_we) begin
				root_q <= cfg_wdata;
				walk_q <= cfg_wdata;
			end
		end
	end

	// Payload registers: load the byte on accept, shift it left one bit per completed bit, and capture results.
	always_ff @(posedge clk) begin
		if (!stall) begin
			if (state_q == ST_IDLE && accept) begin
				sh_q <= in_byte << (CNT_W'(BYTE_W) - in_nbits);
			end else if ((state_q == ST_CUR && cur.leaf) || state_q == ST_CHILD) begin
				sh_q <= sh_q << 1;
			end
			if (gen) begin
				pend_q <= gen_res;
			end
			if (push) begin
				out_q      <= pend_q;
				out_last_q <= (state_q == ST_FLUSH);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.symbol;
	assign m_tuser  = {out_last_q, out_q.status};
	assign m_tlast  = out_q.msg_end;

	// Nothing may wait in the pending slot while a new item can be taken.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("pending result left over in idle");

	// Dropping bits after an error always starts from the root.
	a_hold_at_root: assert property (@(posedge clk) disable iff (!arst_n)
		error_hold_q |-> walk_q == root_q)
		else $error("walk left the root while holding an error");

	// The walk states only run with bits left to decode.
	a_bits_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CUR || state_q == ST_CHILD) |-> cnt_q != '0)
		else $error("bit walk with no bits left");

endmodule

// File: rtl/core/htwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
